[sv/atrlp_pkg.sv]
`default_nettype none

package atrlp_pkg;

	localparam int unsigned BUFFER_BYTES_DEF = 256;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam int N_PAT   = 7;
	localparam int PAT_MAX = 11;

	// Pattern slots; the bit of each pattern in the running hit flags
	localparam int PAT_OK     = 0;
	localparam int PAT_PROMPT = 1;
	localparam int PAT_ERROR  = 2;
	localparam int PAT_NOCARR = 3;
	localparam int PAT_CME    = 4;
	localparam int PAT_CMS    = 5;
	localparam int PAT_RING   = 6;

	localparam logic [N_PAT-1:0] ALL_HITS = '1;

	localparam logic [7:0] PAT_TEXT [N_PAT][PAT_MAX] = '{
		'{"O", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{">", " ", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"E", "R", "R", "O", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"N", "O", " ", "C", "A", "R", "R", "I", "E", "R", 8'h00},
		'{"+", "C", "M", "E", " ", "E", "R", "R", "O", "R", ":"},
		'{"+", "C", "M", "S", " ", "E", "R", "R", "O", "R", ":"},
		'{"R", "I", "N", "G", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [3:0] PAT_LEN [N_PAT] = '{
		4'd2, 4'd2, 4'd5, 4'd10, 4'd11, 4'd11, 4'd4
	};

	typedef enum logic [1:0] {
		ACT_RX     = 2'd0,
		ACT_AWAIT  = 2'd1,
		ACT_READ   = 2'd2,
		ACT_RESET  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_UNSOL = 3'd1,
		EV_OK    = 3'd2,
		EV_ERR   = 3'd3,
		EV_READ  = 3'd4
	} event_t;

	// Reduce an 8-bit index modulo depth by conditional subtraction of
	// shifted multiples, largest first.
	function automatic logic [7:0] wrap_index(input logic [7:0] idx, input int unsigned depth);
		logic [7:0]  rem;
		logic [19:0] step;
		rem = idx;
		for (int k = 7; k >= 0; k--) begin
			step = 20'(depth) << k;
			if (step <= 20'd255 && {12'd0, rem} >= step) begin
				rem = rem - step[7:0];
			end
		end
		return rem;
	endfunction

endpackage

`default_nettype wire

[sv/atrlp_req_if.sv]
`default_nettype none

interface atrlp_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] rx_byte;
	logic       expect_prompt;
	logic [7:0] read_index;

	modport source (
		output valid, action, rx_byte, expect_prompt, read_index,
		input  ready
	);

	modport sink (
		input  valid, action, rx_byte, expect_prompt, read_index,
		output ready
	);
endinterface

`default_nettype wire

[sv/atrlp_rsp_if.sv]
`default_nettype none

interface atrlp_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [7:0] text_start;
	logic [7:0] text_length;
	logic [7:0] read_data;

	modport source (
		output valid, event_res, text_start, text_length, read_data,
		input  ready
	);

	modport sink (
		input  valid, event_res, text_start, text_length, read_data,
		output ready
	);
endinterface

`default_nettype wire

[sv/at_response_line_parser_core.sv]
`default_nettype none
// A word taken from req passes the stage 1 input register and then the stage 2 result
// register, whose contents drive rsp.
// Throughput: one word per cycle while rsp is ready; a new word is taken while a finished result
// waits at rsp, and stalls only when both the input and result stages are full and rsp is not ready.
// Reset: arst_n clears mode, fill count, line start and stage valid flags and sets the prefix flags at once;
// the line buffer RAM is not cleared and needs no clearing pass.

module at_response_line_parser_core #(
	parameter int unsigned BUFFER_BYTES = atrlp_pkg::BUFFER_BYTES_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	atrlp_req_if.sink    req,
	atrlp_rsp_if.source  rsp
);

	localparam int unsigned AW  = $clog2(BUFFER_BYTES);
	localparam int unsigned CAP = BUFFER_BYTES - 1;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_LINES  = 2'd1,
		MODE_PROMPT = 2'd2
	} mode_t;

	// Parser state
	mode_t                         mode_q;
	logic [AW-1:0]                 fill_q;
	logic [AW-1:0]                 begin_q;
	logic [atrlp_pkg::N_PAT-1:0]   hits_q;

	// Stage 1: input register
	logic                          valid_s1;
	atrlp_pkg::action_t            action_s1;
	logic [7:0]                    rx_s1;
	logic                          prompt_s1;
	logic                          byp_s1;
	logic [7:0]                    byp_data_s1;

	// Stage 2: result register
	logic                          valid_s2;
	atrlp_pkg::event_t             event_s2;
	logic [7:0]                    start_s2;
	logic [7:0]                    length_s2;
	logic [7:0]                    data_s2;

	logic                          advance;
	logic                          accept;

	// Buffer RAM port signals
	logic                          wr_en;
	logic [AW-1:0]                 rd_addr;
	logic                          rd_en;
	logic [7:0]                    ram_q;
	logic [7:0]                    ch;

	// Per-word combinational results
	logic                          stored;
	logic [AW-1:0]                 pos;
	logic [AW-1:0]                 fill_inc;
	logic [AW-1:0]                 cnt;
	logic [AW-1:0]                 text_end;
	logic [AW-1:0]                 tlen;
	logic [atrlp_pkg::N_PAT-1:0]   hits_t;
	logic [atrlp_pkg::N_PAT-1:0]   hit;
	logic                          is_prompt;
	logic                          line_end;

	mode_t                         mode_n;
	logic [AW-1:0]                 fill_n;
	logic [AW-1:0]                 begin_n;
	logic [atrlp_pkg::N_PAT-1:0]   hits_n;
	atrlp_pkg::event_t             event_n;
	logic [AW-1:0]                 start_n;
	logic [AW-1:0]                 length_n;
	logic [7:0]                    data_n;

	// Advance stage 1 when the result register is empty or being drained
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	// CR is stored as LF
	assign ch = (rx_s1 == atrlp_pkg::CH_CR) ? atrlp_pkg::CH_LF : rx_s1;

	assign rd_en   = accept && (atrlp_pkg::action_t'(req.action) == atrlp_pkg::ACT_READ);
	assign rd_addr = AW'(atrlp_pkg::wrap_index(req.read_index, BUFFER_BYTES));
	assign wr_en   = advance && (action_s1 == atrlp_pkg::ACT_RX) && stored;

	atrlp_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_BYTES)
	) u_buf (
		.clk   (clk),
		.we    (wr_en),
		.waddr (fill_q),
		.wdata (ch),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_q)
	);

	// Running prefix flags and line end decision for a received byte
	always_comb begin
		stored   = fill_q < AW'(CAP);
		pos      = fill_q - begin_q;
		hits_t   = hits_q;
		if (stored && ch != atrlp_pkg::CH_LF) begin
			for (int i = 0; i < atrlp_pkg::N_PAT; i++) begin
				if (pos < AW'(atrlp_pkg::PAT_LEN[i]) &&
				    atrlp_pkg::PAT_TEXT[i][pos[3:0]] != ch) begin
					hits_t[i] = 1'b0;
				end
			end
		end
		fill_inc = fill_q + AW'(stored);
		cnt      = fill_inc - begin_q;
		// "> " at the line start, both bytes held as non line-end bytes
		is_prompt = (mode_q == MODE_PROMPT) && (cnt == AW'(2)) &&
		            hits_t[atrlp_pkg::PAT_PROMPT] &&
		            !(stored && ch == atrlp_pkg::CH_LF);
		line_end = (ch == atrlp_pkg::CH_LF) || is_prompt;
		// A stored LF is the separator, not part of the text
		text_end = (ch == atrlp_pkg::CH_LF && stored) ? fill_q : fill_inc;
		tlen     = text_end - begin_q;
		for (int i = 0; i < atrlp_pkg::N_PAT; i++) begin
			hit[i] = hits_t[i] && (tlen >= AW'(atrlp_pkg::PAT_LEN[i]));
		end
	end

	// Next state and result for the word in stage 1
	always_comb begin
		mode_n   = mode_q;
		fill_n   = fill_q;
		begin_n  = begin_q;
		hits_n   = hits_q;
		event_n  = atrlp_pkg::EV_NONE;
		start_n  = '0;
		length_n = '0;
		data_n   = '0;
		case (action_s1)
			atrlp_pkg::ACT_RX: begin
				fill_n = fill_inc;
				hits_n = hits_t;
				if (line_end) begin
					if (hit[atrlp_pkg::PAT_RING] || mode_q == MODE_IDLE) begin
						// Report the line, then drop it from the buffer
						event_n  = atrlp_pkg::EV_UNSOL;
						start_n  = begin_q;
						length_n = tlen;
						fill_n   = begin_q;
						hits_n   = atrlp_pkg::ALL_HITS;
					end else if (hit[atrlp_pkg::PAT_ERROR] || hit[atrlp_pkg::PAT_NOCARR] ||
					             hit[atrlp_pkg::PAT_CME] || hit[atrlp_pkg::PAT_CMS]) begin
						event_n  = atrlp_pkg::EV_ERR;
						length_n = text_end;
						mode_n   = MODE_IDLE;
						fill_n   = '0;
						begin_n  = '0;
						hits_n   = atrlp_pkg::ALL_HITS;
					end else if (hit[atrlp_pkg::PAT_OK] || hit[atrlp_pkg::PAT_PROMPT]) begin
						event_n  = atrlp_pkg::EV_OK;
						length_n = text_end;
						mode_n   = MODE_IDLE;
						fill_n   = '0;
						begin_n  = '0;
						hits_n   = atrlp_pkg::ALL_HITS;
					end else begin
						// Intermediate line: keep it unless empty
						if (tlen == '0) begin
							fill_n = begin_q;
						end else begin
							begin_n = fill_inc;
						end
						hits_n = atrlp_pkg::ALL_HITS;
					end
				end
			end
			atrlp_pkg::ACT_AWAIT: begin
				mode_n = prompt_s1 ? MODE_PROMPT : MODE_LINES;
			end
			atrlp_pkg::ACT_READ: begin
				event_n = atrlp_pkg::EV_READ;
				data_n  = byp_s1 ? byp_data_s1 : ram_q;
			end
			atrlp_pkg::ACT_RESET: begin
				mode_n  = MODE_IDLE;
				fill_n  = '0;
				begin_n = '0;
				hits_n  = atrlp_pkg::ALL_HITS;
			end
			default: begin
				mode_n = mode_q;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			fill_q   <= '0;
			begin_q  <= '0;
			hits_q   <= atrlp_pkg::ALL_HITS;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				mode_q   <= mode_n;
				fill_q   <= fill_n;
				begin_q  <= begin_n;
				hits_q   <= hits_n;
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1   <= atrlp_pkg::action_t'(req.action);
			rx_s1       <= req.rx_byte;
			prompt_s1   <= req.expect_prompt;
			// Hold the byte written at the same edge as the read
			byp_s1      <= wr_en && (fill_q == rd_addr);
			byp_data_s1 <= ch;
		end
		if (advance) begin
			event_s2  <= event_n;
			start_s2  <= 8'(start_n);
			length_s2 <= 8'(length_n);
			data_s2   <= data_n;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.event_res   = event_s2;
	assign rsp.text_start  = start_s2;
	assign rsp.text_length = length_s2;
	assign rsp.read_data   = data_s2;

	// Line start never passes the fill point, which never passes capacity
	a_fill_order: assert property (@(posedge clk) disable iff (!arst_n)
		begin_q <= fill_q && fill_q <= AW'(CAP))
		else $error("line start or fill count out of order");

	// A final response leaves the parser idle with an empty buffer
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (event_n == atrlp_pkg::EV_OK || event_n == atrlp_pkg::EV_ERR)
		|=> mode_q == MODE_IDLE && fill_q == '0 && begin_q == '0)
		else $error("final response did not return to idle");

	// Buffer writes only from a received byte leaving stage 1
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> valid_s1 && action_s1 == atrlp_pkg::ACT_RX && fill_q < AW'(CAP))
		else $error("buffer write without a stored byte");

	// Read results carry no text span
	a_read_span: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && event_s2 == atrlp_pkg::EV_READ |-> start_s2 == '0 && length_s2 == '0)
		else $error("read result with a text span");

endmodule

`default_nettype wire

[sv/atrlp_ram.sv]
`default_nettype none

module atrlp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
